>>> hw/rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam int unsigned TOKEN_LEN_MAX = 16'hFFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_POP_A,
    ST_POP_B,
    ST_PUSH_SUM,
    ST_READ_BOTTOM,
    ST_CONVERT,
    ST_EMIT_SIGN,
    ST_EMIT_DIGITS,
    ST_EMIT_BYE,
    ST_ECHO_RD,
    ST_ECHO_OUT,
    ST_EMIT_TAIL,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    TOK_NUMBER,
    TOK_PLUS,
    TOK_DROP,
    TOK_PRINT,
    TOK_QUIT,
    TOK_OTHER
  } token_kind_t;

  function automatic logic [7:0] bye_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h62;
      3'd1: c = 8'h79;
      3'd2: c = 8'h65;
      3'd3: c = 8'h21;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tail_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = CH_SPACE;
      2'd1: c = CH_QMARK;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rpn_stream_if.sv
`default_nettype none
interface rpn_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  logic         last;
  modport source (output valid, output data, output last, input ready);
  modport sink   (input valid, input data, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rpn_ram.sv
`default_nettype none
module rpn_ram #(
  parameter int DEPTH = 64,
  parameter int W     = 32,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/rpn_dec_conv.sv
`default_nettype none
// binary to decimal, one digit per cycle, least significant first into a register file
module rpn_dec_conv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] mag_in,
  output logic             busy,
  output logic [3:0]       ndigits,
  input  wire logic [3:0]  rd_idx,
  output logic [3:0]       rd_digit
);
  logic [31:0] mag;
  logic [3:0]  digs [10];
  logic [31:0] quot;
  logic [3:0]  rem;
  logic [63:0] prod;

  // divide by ten through the reciprocal; the remainder follows from the quotient
  always_comb begin
    prod = {32'd0, mag} * 64'hCCCC_CCCD;
    quot = 32'(prod >> 35);
    rem  = 4'(mag - quot * 32'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      ndigits <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      ndigits <= '0;
      mag     <= mag_in;
    end else if (busy) begin
      digs[ndigits] <= rem;
      ndigits       <= ndigits + 4'd1;
      mag           <= quot;
      if (quot == 32'd0 || ndigits == 4'd9) begin
        busy <= 1'b0;
      end
    end
  end

  assign rd_digit = digs[rd_idx];
endmodule
`default_nettype wire

>>> hw/rtl/rpn_stack_calculator.sv
`default_nettype none
// rpn calculator: text in one byte per transfer on in_ch, characters out on out_ch.
// out_ch.last marks the final character caused by one input byte.
// a delimiter that ends a token runs it: '+' pops two values and pushes their sum,
// '.' prints the bottom value as a minus sign if negative, its digits and a newline,
// a quit word prints "bye!" and a newline, and any other word is echoed followed
// by " ?" and a newline; numbers are pushed and 'drop' pops.
// the steps are set by the value stack and token buffer memories, each with a
// registered read port, and by the one-digit-a-cycle decimal converter.
// reset clears the stack count, token state and the halt flags; the memories
// keep their contents and are only read where written.
// the output is a registered stage: when out_ch.ready is low the sequencer waits
// and no further input is taken until all characters of a byte are out.
// after a quit word, the newline that ends its line halts the block; later
// input is taken and dropped.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_TOKEN   = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  rpn_stream_if.sink   in_ch,
  rpn_stream_if.source out_ch
);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int TAW = $clog2(MAX_TOKEN);

  rpn_pkg::state_t state, state_next;

  logic [SCW-1:0] stack_count;
  logic [15:0]    token_length;
  logic [31:0]    digit_value;
  logic           all_digits_flag;
  logic           quit_seen;
  logic           halted;
  logic [7:0]     in_byte;
  logic [31:0]    pop_a;
  logic [31:0]    bottom;
  logic [7:0]     c0, c1, c2, c3;
  logic [15:0]    echo_idx;
  logic [3:0]     digit_idx;
  logic [2:0]     str_idx;
  logic           neg;
  rpn_pkg::token_kind_t kind;

  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [31:0]    s_wdata, s_rdata;
  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [7:0]     t_rdata;

  logic           conv_start, conv_busy;
  logic [3:0]     conv_n, conv_digit;

  logic           out_valid;
  logic [7:0]     out_char;
  logic           out_last;
  logic           out_free;
  logic           out_load;
  logic           is_delim;
  logic [15:0]    shown;

  rpn_ram #(.DEPTH(STACK_DEPTH), .W(32), .AW(SAW)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  rpn_ram #(.DEPTH(MAX_TOKEN), .W(8), .AW(TAW)) u_token (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(in_ch.data), .raddr(t_raddr), .rdata(t_rdata)
  );
  rpn_dec_conv u_conv (
    .clk, .rst, .start(conv_start), .mag_in(neg ? 32'(-bottom) : bottom),
    .busy(conv_busy), .ndigits(conv_n), .rd_idx(digit_idx), .rd_digit(conv_digit)
  );

  assign out_free  = !out_valid || out_ch.ready;
  assign out_load  = out_free && (state == rpn_pkg::ST_EMIT_SIGN ||
                                  state == rpn_pkg::ST_EMIT_DIGITS ||
                                  state == rpn_pkg::ST_EMIT_BYE ||
                                  state == rpn_pkg::ST_ECHO_OUT ||
                                  state == rpn_pkg::ST_EMIT_TAIL);
  assign in_ch.ready = (state == rpn_pkg::ST_IDLE) && out_free;
  assign is_delim  = (in_ch.data == rpn_pkg::CH_SPACE) || (in_ch.data == rpn_pkg::CH_NL);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_char;
  assign out_ch.last  = out_last;
  assign shown = (token_length < 16'(MAX_TOKEN)) ? token_length : 16'(MAX_TOKEN);

  // token buffer written directly on transfer
  assign t_we    = in_ch.valid && in_ch.ready && !halted && !is_delim &&
                   (token_length < 16'(MAX_TOKEN));
  assign t_waddr = TAW'(token_length);

  // classification from the first four characters, kept beside the memory
  always_comb begin
    kind = rpn_pkg::TOK_OTHER;
    if (all_digits_flag) begin
      kind = rpn_pkg::TOK_NUMBER;
    end else if (token_length == 16'd1 && c0 == 8'h2B) begin
      kind = rpn_pkg::TOK_PLUS;
    end else if (token_length == 16'd1 && c0 == 8'h2E) begin
      kind = rpn_pkg::TOK_PRINT;
    end else if (token_length == 16'd4 && c0 == 8'h64 && c1 == 8'h72 &&
                 c2 == 8'h6F && c3 == 8'h70) begin
      kind = rpn_pkg::TOK_DROP;
    end else if ((token_length == 16'd3 && c0 == 8'h62 && c1 == 8'h79 && c2 == 8'h65) ||
                 (token_length == 16'd4 && c0 == 8'h71 && c1 == 8'h75 &&
                  c2 == 8'h69 && c3 == 8'h74) ||
                 (token_length == 16'd4 && c0 == 8'h65 && c1 == 8'h78 &&
                  c2 == 8'h69 && c3 == 8'h74)) begin
      kind = rpn_pkg::TOK_QUIT;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready && !halted && is_delim) begin
          state_next = (token_length != 16'd0) ? rpn_pkg::ST_CLASSIFY : rpn_pkg::ST_FINISH;
        end
      end
      rpn_pkg::ST_CLASSIFY: begin
        unique case (kind)
          rpn_pkg::TOK_NUMBER: state_next = rpn_pkg::ST_FINISH;
          rpn_pkg::TOK_PLUS:   state_next = rpn_pkg::ST_POP_A;
          rpn_pkg::TOK_DROP:   state_next = rpn_pkg::ST_FINISH;
          rpn_pkg::TOK_PRINT:  state_next = rpn_pkg::ST_READ_BOTTOM;
          rpn_pkg::TOK_QUIT:   state_next = rpn_pkg::ST_EMIT_BYE;
          default:             state_next = rpn_pkg::ST_ECHO_RD;
        endcase
      end
      rpn_pkg::ST_POP_A:       state_next = rpn_pkg::ST_POP_B;
      rpn_pkg::ST_POP_B:       state_next = rpn_pkg::ST_PUSH_SUM;
      rpn_pkg::ST_PUSH_SUM:    state_next = rpn_pkg::ST_FINISH;
      rpn_pkg::ST_READ_BOTTOM: state_next = rpn_pkg::ST_CONVERT;
      rpn_pkg::ST_CONVERT: begin
        if (str_idx == 3'd3 && !conv_busy) begin
          state_next = neg ? rpn_pkg::ST_EMIT_SIGN : rpn_pkg::ST_EMIT_DIGITS;
        end
      end
      rpn_pkg::ST_EMIT_SIGN:   if (out_free) state_next = rpn_pkg::ST_EMIT_DIGITS;
      rpn_pkg::ST_EMIT_DIGITS: begin
        if (out_free && digit_idx == 4'd0 && str_idx == 3'd1) state_next = rpn_pkg::ST_FINISH;
      end
      rpn_pkg::ST_EMIT_BYE:    if (out_free && str_idx == 3'd4) state_next = rpn_pkg::ST_FINISH;
      rpn_pkg::ST_ECHO_RD: begin
        state_next = (echo_idx < shown) ? rpn_pkg::ST_ECHO_OUT : rpn_pkg::ST_EMIT_TAIL;
      end
      rpn_pkg::ST_ECHO_OUT:    if (out_free) state_next = rpn_pkg::ST_ECHO_RD;
      rpn_pkg::ST_EMIT_TAIL:   if (out_free && str_idx == 3'd2) state_next = rpn_pkg::ST_FINISH;
      rpn_pkg::ST_FINISH:      state_next = rpn_pkg::ST_IDLE;
      default:                 state_next = rpn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = SAW'(stack_count);
    s_wdata = digit_value;
    s_raddr = SAW'(stack_count - SCW'(1));
    t_raddr = TAW'(echo_idx);
    conv_start = 1'b0;
    unique case (state)
      rpn_pkg::ST_CLASSIFY: begin
        if (kind == rpn_pkg::TOK_NUMBER && stack_count < SCW'(STACK_DEPTH)) s_we = 1'b1;
      end
      rpn_pkg::ST_POP_A: s_raddr = SAW'(stack_count - SCW'(2));
      rpn_pkg::ST_PUSH_SUM: begin
        s_we    = 1'b1;
        s_waddr = SAW'(stack_count);
        s_wdata = pop_a;
      end
      rpn_pkg::ST_READ_BOTTOM: begin
        s_raddr    = '0;
      end
      default: ;
    endcase
    // bottom and neg are registered in the cycle before the converter starts
    if (state == rpn_pkg::ST_CONVERT && str_idx == 3'd2) conv_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= rpn_pkg::ST_IDLE;
      stack_count     <= '0;
      token_length    <= '0;
      digit_value     <= '0;
      all_digits_flag <= 1'b1;
      quit_seen       <= 1'b0;
      halted          <= 1'b0;
      out_valid       <= 1'b0;
      str_idx         <= '0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        rpn_pkg::ST_IDLE: begin
          if (in_ch.valid && in_ch.ready && !halted) begin
            in_byte <= in_ch.data;
            if (!is_delim) begin
              if (token_length < 16'(MAX_TOKEN)) begin
                unique case (token_length[1:0])
                  2'd0: if (token_length == 16'd0) c0 <= in_ch.data;
                  2'd1: if (token_length == 16'd1) c1 <= in_ch.data;
                  2'd2: if (token_length == 16'd2) c2 <= in_ch.data;
                  default: if (token_length == 16'd3) c3 <= in_ch.data;
                endcase
              end
              if (token_length < 16'(rpn_pkg::TOKEN_LEN_MAX)) token_length <= token_length + 16'd1;
              if (in_ch.data >= rpn_pkg::CH_ZERO && in_ch.data <= rpn_pkg::CH_NINE) begin
                digit_value <= 32'(digit_value * 32'd10) + 32'(in_ch.data - rpn_pkg::CH_ZERO);
              end else begin
                all_digits_flag <= 1'b0;
              end
            end
          end
        end
        rpn_pkg::ST_CLASSIFY: begin
          echo_idx <= '0;
          str_idx  <= '0;
          if (kind == rpn_pkg::TOK_NUMBER && stack_count < SCW'(STACK_DEPTH)) begin
            stack_count <= stack_count + SCW'(1);
          end
          if (kind == rpn_pkg::TOK_DROP && stack_count != '0) begin
            stack_count <= stack_count - SCW'(1);
          end
        end
        rpn_pkg::ST_POP_A: begin
          // first pop data returns this cycle; zero if the stack was empty
          pop_a <= (stack_count != '0) ? s_rdata : 32'd0;
          if (stack_count != '0) stack_count <= stack_count - SCW'(1);
        end
        rpn_pkg::ST_POP_B: begin
          // pop_a now carries the sum b + a
          pop_a <= pop_a + ((stack_count != '0) ? s_rdata : 32'd0);
          if (stack_count != '0) stack_count <= stack_count - SCW'(1);
        end
        rpn_pkg::ST_PUSH_SUM: begin
          if (stack_count < SCW'(STACK_DEPTH)) stack_count <= stack_count + SCW'(1);
        end
        rpn_pkg::ST_READ_BOTTOM: ;
        rpn_pkg::ST_CONVERT: begin
          if (str_idx == 3'd0) begin
            bottom  <= (stack_count != '0) ? s_rdata : 32'd0;
            neg     <= (stack_count != '0) ? s_rdata[31] : 1'b0;
            str_idx <= 3'd2;
          end else if (str_idx == 3'd2) begin
            str_idx <= 3'd3;
          end else if (!conv_busy) begin
            digit_idx <= conv_n - 4'd1;
            str_idx   <= '0;
          end
        end
        rpn_pkg::ST_EMIT_SIGN: begin
          if (out_free) begin
            out_char  <= rpn_pkg::CH_MINUS;
            out_last  <= 1'b0;
          end
        end
        rpn_pkg::ST_EMIT_DIGITS: begin
          if (out_free) begin
            if (str_idx == 3'd0) begin
              out_char <= rpn_pkg::CH_ZERO + {4'd0, conv_digit};
              out_last <= 1'b0;
              if (digit_idx == 4'd0) str_idx <= 3'd1;
              else digit_idx <= digit_idx - 4'd1;
            end else begin
              out_char <= rpn_pkg::CH_NL;
              out_last <= 1'b1;
              str_idx  <= '0;
            end
          end
        end
        rpn_pkg::ST_EMIT_BYE: begin
          if (out_free) begin
            out_char  <= rpn_pkg::bye_char(str_idx);
            out_last  <= (str_idx == 3'd4);
            str_idx   <= str_idx + 3'd1;
            quit_seen <= 1'b1;
          end
        end
        rpn_pkg::ST_ECHO_RD: str_idx <= '0;
        rpn_pkg::ST_ECHO_OUT: begin
          if (out_free) begin
            out_char  <= t_rdata;
            out_last  <= 1'b0;
            echo_idx  <= echo_idx + 16'd1;
          end
        end
        rpn_pkg::ST_EMIT_TAIL: begin
          if (out_free) begin
            out_char  <= rpn_pkg::tail_char(str_idx[1:0]);
            out_last  <= (str_idx == 3'd2);
            str_idx   <= str_idx + 3'd1;
          end
        end
        rpn_pkg::ST_FINISH: begin
          token_length    <= '0;
          digit_value     <= '0;
          all_digits_flag <= 1'b1;
          str_idx         <= '0;
          if (in_byte == rpn_pkg::CH_NL && (quit_seen)) halted <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output must not be replaced while a character waits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_char))
    else $error("output overwritten while stalled");

  // no input taken while a token is being executed
  assert property (@(posedge clk) disable iff (rst)
    state != rpn_pkg::ST_IDLE |-> !in_ch.ready)
    else $error("input accepted while busy");

  // stack count never exceeds the depth
  assert property (@(posedge clk) disable iff (rst)
    stack_count <= SCW'(STACK_DEPTH))
    else $error("stack count overflow");

endmodule
`default_nettype wire

>>> tb/sv/rpn_stack_calculator_tb.sv
`timescale 1ns / 1ps
module rpn_stack_calculator_tb;

  localparam int STACK_DEPTH = 64;
  localparam int MAX_TOKEN   = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } out_char_t;

  logic clk;
  logic rst;

  rpn_stream_if #(.W(8)) in_ch ();
  rpn_stream_if #(.W(8)) out_ch ();

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_TOKEN  (MAX_TOKEN)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  logic [31:0] calc_stack [STACK_DEPTH];
  int unsigned calc_depth;
  logic [7:0]  word_buf [MAX_TOKEN];
  int unsigned word_len;
  logic [31:0] number_acc;
  bit          only_digits;
  bit          quit_pending;
  bit          stopped;

  logic [7:0]  text_queue [$];
  out_char_t   expected_chars [$];
  out_char_t   byte_chars [$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned holdoff_left;
  bit          holdoff_done;
  bit          text_done;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit word_is(string w);
    if (word_len != w.len() || word_len > MAX_TOKEN) return 0;
    for (int i = 0; i < w.len(); i++)
      if (word_buf[i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic rpn_pkg::token_kind_t word_kind();
    if (only_digits) return rpn_pkg::TOK_NUMBER;
    if (word_is("+")) return rpn_pkg::TOK_PLUS;
    if (word_is("drop")) return rpn_pkg::TOK_DROP;
    if (word_is(".")) return rpn_pkg::TOK_PRINT;
    if (word_is("bye") || word_is("quit") || word_is("exit")) return rpn_pkg::TOK_QUIT;
    return rpn_pkg::TOK_OTHER;
  endfunction

  function automatic void put_char(logic [7:0] c);
    byte_chars.push_back('{ch: c, lst: 1'b0});
  endfunction

  function automatic void push_value(logic [31:0] v);
    if (calc_depth < STACK_DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endfunction

  function automatic logic [31:0] pop_value();
    if (calc_depth == 0) return 32'd0;
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  function automatic void print_decimal(logic [31:0] v);
    logic [7:0]  digs [10];
    int          n;
    logic [31:0] mag;
    n = 0;
    mag = v;
    if (v[31]) begin
      put_char(rpn_pkg::CH_MINUS);
      mag = -v;
    end
    do begin
      digs[n] = rpn_pkg::CH_ZERO + 8'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < 10);
    while (n > 0) begin
      n--;
      put_char(digs[n]);
    end
    put_char(rpn_pkg::CH_NL);
  endfunction

  function automatic void run_word();
    logic [31:0] a, b;
    int unsigned shown;
    case (word_kind())
      rpn_pkg::TOK_NUMBER: push_value(number_acc);
      rpn_pkg::TOK_PLUS: begin
        a = pop_value();
        b = pop_value();
        push_value(b + a);
      end
      rpn_pkg::TOK_DROP: a = pop_value();
      rpn_pkg::TOK_PRINT: print_decimal(calc_depth > 0 ? calc_stack[0] : 32'd0);
      rpn_pkg::TOK_QUIT: begin
        for (int i = 0; i < 5; i++) put_char(rpn_pkg::bye_char(3'(i)));
        quit_pending = 1;
      end
      default: begin
        shown = word_len < MAX_TOKEN ? word_len : MAX_TOKEN;
        for (int i = 0; i < shown; i++) put_char(word_buf[i]);
        for (int i = 0; i < 3; i++) put_char(rpn_pkg::tail_char(2'(i)));
      end
    endcase
  endfunction

  // works out the characters one accepted input byte gives
  function automatic void predict_byte(logic [7:0] c);
    out_char_t lastc;
    byte_chars.delete();
    if (stopped) return;
    if (c == rpn_pkg::CH_SPACE || c == rpn_pkg::CH_NL) begin
      if (word_len > 0) run_word();
      word_len = 0;
      number_acc = 0;
      only_digits = 1;
      if (c == rpn_pkg::CH_NL && quit_pending) stopped = 1;
    end else begin
      if (word_len < MAX_TOKEN) word_buf[word_len] = c;
      if (word_len < rpn_pkg::TOKEN_LEN_MAX) word_len++;
      if (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE)
        number_acc = number_acc * 10 + 32'(c - rpn_pkg::CH_ZERO);
      else only_digits = 0;
    end
    if (byte_chars.size() > 0) begin
      lastc = byte_chars.pop_back();
      lastc.lst = 1'b1;
      byte_chars.push_back(lastc);
    end
    foreach (byte_chars[i]) expected_chars.push_back(byte_chars[i]);
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_queue.push_back(s[i]);
  endtask

  task automatic add_random_word();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      n = $urandom_range(1, 11);
      for (int i = 0; i < n; i++)
        text_queue.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r < 55) add_text("+");
    else if (r < 63) add_text("drop");
    else if (r < 72) add_text(".");
    else if (r < 80) begin
      case ($urandom_range(0, 4))
        0: add_text("dro");
        1: add_text("drops");
        2: add_text("by");
        3: add_text("++");
        default: add_text("1+");
      endcase
    end else begin
      // noise word: any byte but the delimiters
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 255);
        if (r == rpn_pkg::CH_SPACE || r == rpn_pkg::CH_NL) r = r + 1;
        text_queue.push_back(8'(r));
      end
    end
    text_queue.push_back($urandom_range(0, 5) == 0 ? rpn_pkg::CH_NL : rpn_pkg::CH_SPACE);
    if ($urandom_range(0, 9) == 0) text_queue.push_back(rpn_pkg::CH_SPACE);
  endtask

  initial begin
    rst = 1'b1;
    clk = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = 8'h00;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    calc_depth = 0;
    word_len = 0;
    number_acc = 0;
    only_digits = 1;
    quit_pending = 0;
    stopped = 0;
    mismatches = 0;
    text_done = 0;

    // directed part
    add_text(". + . drop\n");
    add_text("1 2 + . drop\n");
    add_text("4294967295 . drop 2147483648 . drop  \n\n");
    add_text("99999999999 . drop\n");
    add_text("1234567890123456789012345678901234567890 . drop\n");
    add_text("abcdefghijklmnopqrstuvwxyz0123456789ABC\n");
    text_queue.push_back(8'h00);
    text_queue.push_back(8'hFF);
    add_text(" drop drop drop\n");

    // enough pushes to fill the stack and overflow it
    for (int i = 0; i < 66; i++) add_text("7 ");
    add_text(". + .\n");

    while (text_queue.size() < 340) add_random_word();
    add_text("\nexit 5 . quit bye\n");
    for (int i = 0; i < 10; i++) text_queue.push_back(8'($urandom_range(0, 255)));
    text_done = 1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (text_queue.size() == 0 && !in_ch.valid);
    wait (expected_chars.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= 8'h00;
      in_ch.last <= 1'b0;
      send_gap <= 0;
      bytes_sent <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (text_done && text_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= text_queue.pop_front();
        bytes_sent <= bytes_sent + 1;
        // stretches with no idling at all
        send_gap <= (bytes_sent % 200 < 60) ? 0 : pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off mid run
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      holdoff_left <= 0;
      holdoff_done <= 0;
    end else if (!holdoff_done && bytes_sent == 300) begin
      holdoff_done <= 1;
      holdoff_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap <= (bytes_sent % 250 < 70) ? 0 : pick_gap();
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    out_char_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected char %h last %b", out_ch.data, out_ch.last);
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.data !== want.ch || out_ch.last !== want.lst) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.ch, want.lst, out_ch.data, out_ch.last);
          end
        end
      end
    end
  end

endmodule
